FILE: sv/bdr_pkg.sv
// Package for the button debounce / autorepeat block.
// Widths, register codes, reset values and shared config structs.
// No dependencies.
`default_nettype none

package bdr_pkg;

  localparam int NumChannels   = 9;
  localparam int RawW          = 5;
  localparam int AxisW         = 12;
  localparam int StepW         = 8;
  localparam int TimeW         = 10;
  localparam int HoldW         = 11;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 12;
  localparam int InTdataW      = 32;
  localparam int OutTdataW     = 24;

  localparam int DefNumButtons   = 5;
  localparam int DefPressedLevel = 10;

  localparam logic [HoldW-1:0] HoldMax = 11'h7FF;

  localparam int BitRight = 5;
  localparam int BitLeft  = 6;
  localparam int BitUp    = 7;
  localparam int BitDown  = 8;

  localparam logic [StepW-1:0] RstIncStep        = 8'd1;
  localparam logic [StepW-1:0] RstDecStep        = 8'd1;
  localparam logic [AxisW-1:0] RstUpperPress     = 12'd3000;
  localparam logic [AxisW-1:0] RstUpperRelease   = 12'd2500;
  localparam logic [AxisW-1:0] RstLowerPress     = 12'd1000;
  localparam logic [AxisW-1:0] RstLowerRelease   = 12'd1500;
  localparam logic [TimeW-1:0] RstRepeatFirst    = 10'd100;
  localparam logic [TimeW-1:0] RstRepeatInterval = 10'd10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INC_STEP        = 3'd0,
    REG_DEC_STEP        = 3'd1,
    REG_UPPER_PRESS     = 3'd2,
    REG_UPPER_RELEASE   = 3'd3,
    REG_LOWER_PRESS     = 3'd4,
    REG_LOWER_RELEASE   = 3'd5,
    REG_REPEAT_FIRST    = 3'd6,
    REG_REPEAT_INTERVAL = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [AxisW-1:0] upper_press;
    logic [AxisW-1:0] upper_release;
    logic [AxisW-1:0] lower_press;
    logic [AxisW-1:0] lower_release;
  } bdr_thresh_t;

  typedef struct packed {
    logic [TimeW-1:0] first_ticks;
    logic [TimeW-1:0] interval;
  } bdr_repeat_cfg_t;

endpackage

`default_nettype wire

FILE: sv/bdr_integrator.sv
// One button lane: up/down integrator with clamp and set/clear decision.
// Depends on bdr_pkg.
`default_nettype none

module bdr_integrator import bdr_pkg::*; #(
  parameter int PRESSED_LEVEL = DefPressedLevel
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             raw_i,
  input  wire logic             old_i,
  input  wire logic [StepW-1:0] inc_step_i,
  input  wire logic [StepW-1:0] dec_step_i,
  output logic                  bit_o
);

  localparam logic [StepW-1:0] Top = StepW'(PRESSED_LEVEL);

  logic [StepW-1:0] level_q, level_d;
  logic [StepW:0]   sum;

  assign sum = {1'b0, level_q} + {1'b0, inc_step_i};

  always_comb begin
    level_d = level_q;
    bit_o   = old_i;
    if (raw_i) begin
      if (sum >= {1'b0, Top}) begin
        level_d = Top;
        bit_o   = 1'b1;
      end else begin
        level_d = sum[StepW-1:0];
      end
    end else if (level_q <= dec_step_i) begin
      level_d = '0;
      bit_o   = 1'b0;
    end else begin
      level_d = level_q - dec_step_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bdr_axis.sv
// One joystick axis lane: press/release hysteresis for the high and low direction.
// Depends on bdr_pkg.
`default_nettype none

module bdr_axis import bdr_pkg::*; (
  input  wire logic [AxisW-1:0] sample_i,
  input  wire bdr_thresh_t      thresh_i,
  input  wire logic             old_hi_i,
  input  wire logic             old_lo_i,
  output logic                  hi_o,
  output logic                  lo_o
);

  // release is tested last so it wins when both thresholds apply
  always_comb begin
    hi_o = old_hi_i;
    lo_o = old_lo_i;
    if (sample_i > thresh_i.upper_press)   hi_o = 1'b1;
    if (sample_i < thresh_i.upper_release) hi_o = 1'b0;
    if (sample_i < thresh_i.lower_press)   lo_o = 1'b1;
    if (sample_i > thresh_i.lower_release) lo_o = 1'b0;
  end

endmodule

`default_nettype wire

FILE: sv/bdr_repeat.sv
// One autorepeat lane: saturating hold counter and repeat pulse.
// Depends on bdr_pkg.
`default_nettype none

module bdr_repeat import bdr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            bit_i,
  input  wire bdr_repeat_cfg_t cfg_i,
  output logic                 pulse_o
);

  logic [HoldW-1:0] cnt_q, cnt_d, cnt_inc, limit, first;

  assign first   = {1'b0, cfg_i.first_ticks};
  assign limit   = {1'b0, cfg_i.first_ticks} + {1'b0, cfg_i.interval};
  assign cnt_inc = (cnt_q == HoldMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cnt_d   = '0;
    pulse_o = 1'b0;
    if (bit_i) begin
      if (cnt_inc >= limit) begin
        pulse_o = 1'b1;
        cnt_d   = first;
      end else begin
        pulse_o = (cnt_inc == first);
        cnt_d   = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_debounce_repeat.sv
// Top level: config registers, button/axis/repeat lanes, merge and output skid.
// Depends on bdr_pkg, bdr_integrator, bdr_axis, bdr_repeat.
`default_nettype none

// One word in gives one word out. Every lane (button integrators, axis
// comparators, hold counters) computes its result combinationally, so a word
// is accepted every clock while the skid is empty, and its result is loaded
// into the output register, or into a one-word skid behind it while a result
// waits there; s_axis_tready drops only when both are full. Config writes take
// effect at the next clock edge.
module button_debounce_repeat import bdr_pkg::*; #(
  parameter int NUM_BUTTONS   = DefNumButtons,
  parameter int PRESSED_LEVEL = DefPressedLevel
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // raw_buttons[4:0], joystick_x[16:5], joystick_y[28:17], zero pad
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // debounced_state[8:0], press_events[17:9], zero pad
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  localparam int ResW = 2 * NumChannels;

  logic [StepW-1:0] inc_step_q, dec_step_q;
  bdr_thresh_t      thresh_q;
  bdr_repeat_cfg_t  rep_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_step_q              <= RstIncStep;
      dec_step_q              <= RstDecStep;
      thresh_q.upper_press    <= RstUpperPress;
      thresh_q.upper_release  <= RstUpperRelease;
      thresh_q.lower_press    <= RstLowerPress;
      thresh_q.lower_release  <= RstLowerRelease;
      rep_cfg_q.first_ticks   <= RstRepeatFirst;
      rep_cfg_q.interval      <= RstRepeatInterval;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_INC_STEP:        inc_step_q             <= cfg_wdata_i[StepW-1:0];
        REG_DEC_STEP:        dec_step_q             <= cfg_wdata_i[StepW-1:0];
        REG_UPPER_PRESS:     thresh_q.upper_press   <= cfg_wdata_i[AxisW-1:0];
        REG_UPPER_RELEASE:   thresh_q.upper_release <= cfg_wdata_i[AxisW-1:0];
        REG_LOWER_PRESS:     thresh_q.lower_press   <= cfg_wdata_i[AxisW-1:0];
        REG_LOWER_RELEASE:   thresh_q.lower_release <= cfg_wdata_i[AxisW-1:0];
        REG_REPEAT_FIRST:    rep_cfg_q.first_ticks  <= cfg_wdata_i[TimeW-1:0];
        REG_REPEAT_INTERVAL: rep_cfg_q.interval     <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  logic                   acc;
  logic [RawW-1:0]        raw;
  logic [AxisW-1:0]       jx, jy;
  logic [NumChannels-1:0] state_q, state_d, rep_pulse, events;
  logic [ResW-1:0]        res;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign raw = s_axis_tdata[RawW-1:0];
  assign jx  = s_axis_tdata[RawW+AxisW-1:RawW];
  assign jy  = s_axis_tdata[RawW+2*AxisW-1:RawW+AxisW];

  for (genvar i = 0; i < RawW; i++) begin : g_btn
    if (i < NUM_BUTTONS) begin : g_on
      bdr_integrator #(.PRESSED_LEVEL(PRESSED_LEVEL)) u_int (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .en_i       (acc),
        .raw_i      (raw[i]),
        .old_i      (state_q[i]),
        .inc_step_i (inc_step_q),
        .dec_step_i (dec_step_q),
        .bit_o      (state_d[i])
      );
    end else begin : g_off
      assign state_d[i] = 1'b0;
    end
  end

  bdr_axis u_axis_x (
    .sample_i (jx),
    .thresh_i (thresh_q),
    .old_hi_i (state_q[BitRight]),
    .old_lo_i (state_q[BitLeft]),
    .hi_o     (state_d[BitRight]),
    .lo_o     (state_d[BitLeft])
  );

  bdr_axis u_axis_y (
    .sample_i (jy),
    .thresh_i (thresh_q),
    .old_hi_i (state_q[BitUp]),
    .old_lo_i (state_q[BitDown]),
    .hi_o     (state_d[BitUp]),
    .lo_o     (state_d[BitDown])
  );

  for (genvar c = 0; c < NumChannels; c++) begin : g_rep
    bdr_repeat u_rep (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (acc),
      .bit_i   (state_d[c]),
      .cfg_i   (rep_cfg_q),
      .pulse_o (rep_pulse[c])
    );
  end

  // merge: rising edges against the pre-tick state, ORed with repeat pulses
  assign events = (~state_q & state_d) | rep_pulse;
  assign res    = {events, state_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (acc) begin
      state_q <= state_d;
    end
  end

  // output register plus skid
  logic            out_v_q, skid_v_q, out_load;
  logic [ResW-1:0] out_q, skid_q;

  assign out_load      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q  <= skid_v_q || acc;
      skid_v_q <= 1'b0;
    end else if (acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res;
      end
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutTdataW-ResW){1'b0}}, out_q};

endmodule

`default_nettype wire

FILE: sv/bdr_checker.sv
// Port-level assertions for button_debounce_repeat, bound to the top level.
// Depends on bdr_pkg and button_debounce_repeat.
`default_nettype none

module bdr_checker import bdr_pkg::*; #(
  parameter int NUM_BUTTONS = DefNumButtons
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutTdataW-1:0] m_axis_tdata
);

  localparam logic [NumChannels-1:0] BtnMask  = NumChannels'((1 << NUM_BUTTONS) - 1);
  localparam logic [NumChannels-1:0] DeadMask = NumChannels'((1 << RawW) - 1) & ~BtnMask;

  logic [NumChannels-1:0] st, ev;
  assign st = m_axis_tdata[NumChannels-1:0];
  assign ev = m_axis_tdata[2*NumChannels-1:NumChannels];

  // a press event is only reported on a bit that is set
  a_event_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((ev & ~st) == '0))
    else $error("press event on a released bit");

  // buttons beyond the configured count never show as pressed
  a_dead_buttons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((st & DeadMask) == '0))
    else $error("unused button bit set");

  // with nothing pending on the output the input side must be open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // after an accepted word the output is valid in the next cycle (its result or an earlier one)
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind button_debounce_repeat bdr_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_bdr_checker (.*);

`default_nettype wire
